>>> hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the residue unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define MRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define MRU_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hdl/mru_pkg.sv
// Package with the types, constants and modular helpers of the residue unit.
`timescale 1ns / 1ps
package mru_pkg;

  localparam int unsigned WordBits = 60;
  localparam int unsigned NumRegs  = 4;

  typedef logic [WordBits-1:0] word_t;

  typedef struct packed {
    logic load;
    logic red;
    logic base_en;
    logic bit_c;
    logic prep;
    logic mul;
    logic upd;
    logic cap;
    logic shift;
  } ctrl_t;

  // One step of a most-significant-first reduction: (2r + b) mod m, r < m.
  function automatic word_t red_step(word_t r, logic b, word_t m);
    logic [WordBits:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[WordBits-1:0];
  endfunction

  // Modular sum of two reduced values.
  function automatic word_t add_mod(word_t a, word_t b, word_t m);
    logic [WordBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WordBits-1:0];
  endfunction

endpackage

>>> hdl/multimodular_residue_unit.sv
// Top level of the multimodular residue unit: control sequencer and row of lane cells.
//
// Input stream: one 60-bit chunk per transfer, least significant chunk first,
// tlast on the most significant chunk. Output stream: after the chunk with
// tlast, one residue per modulus, lane 0 first, with the lane number in tuser
// and tlast on the last lane. Moduli are to be written through the cfg port
// while the block is idle; the block itself does not enforce this. A value
// below two yields residue 0 for that lane. After its transfer each chunk
// passes through bit-serial reduction of chunk, weight and residue, a setup
// step, bit-serial modular multiplication (two products sharing one doubled
// addend) in the shift-and-add loop inside every lane cell, and an update
// step; the block takes no new chunk before that is done. A chunk is taken
// only when the block is idle and no residues are waiting. Results leave
// through a shift chain along the cells, one per cycle while the receiver
// is ready; a stalled receiver holds the chain and the input side stays
// closed until the last residue is transferred.
// Reset sets all moduli to 2 and every lane to residue 0, weight 1.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module multimodular_residue_unit #(
  parameter int unsigned NUM_PRIMES = 4,
  parameter int unsigned CHUNK_BITS = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [59:0] chunk, [63:60] zero
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [59:0] residue, [63:60] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] prime_index
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [59:0] cfg_data_i
);
  import mru_pkg::*;

  localparam word_t ChunkMask = {WordBits{1'b1}} >> (WordBits - CHUNK_BITS);
  localparam logic [5:0] LastCnt = 6'(WordBits - 1);
  localparam logic [1:0] LastIdx = 2'(NUM_PRIMES - 1);

  typedef enum logic [2:0] {S_IDLE, S_RED, S_PREP, S_MUL, S_UPD, S_OUT} st_e;

  st_e        st_q;
  logic [5:0] cnt_q;
  logic [1:0] idx_q;
  word_t      ch_q;
  logic       fin_q;
  word_t      mod_q [NumRegs];
  ctrl_t      ctrl;
  word_t      res [NUM_PRIMES+1];
  logic       in_hs, out_hs;

  assign in_hs  = s_axis_tvalid && s_axis_tready;
  assign out_hs = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = (st_q == S_OUT);
  assign m_axis_tdata  = {4'b0, res[0]};
  assign m_axis_tuser  = idx_q;
  assign m_axis_tlast  = (idx_q == LastIdx);

  always_comb begin
    ctrl         = '0;
    ctrl.load    = in_hs;
    ctrl.red     = (st_q == S_RED);
    ctrl.base_en = (cnt_q < 6'(CHUNK_BITS));
    ctrl.bit_c   = ch_q[WordBits-1];
    ctrl.prep    = (st_q == S_PREP);
    ctrl.mul     = (st_q == S_MUL);
    ctrl.upd     = (st_q == S_UPD);
    ctrl.cap     = (st_q == S_UPD) && fin_q;
    ctrl.shift   = out_hs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        mod_q[i] <= word_t'(2);
      end
    end else if (cfg_we_i) begin
      mod_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
      idx_q <= '0;
      ch_q  <= '0;
      fin_q <= 1'b0;
    end else begin
      unique case (st_q)
        S_IDLE: begin
          if (in_hs) begin
            ch_q  <= s_axis_tdata[WordBits-1:0] & ChunkMask;
            fin_q <= s_axis_tlast;
            cnt_q <= '0;
            st_q  <= S_RED;
          end
        end
        S_RED: begin
          ch_q <= {ch_q[WordBits-2:0], 1'b0};
          if (cnt_q == LastCnt) begin
            st_q <= S_PREP;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_PREP: begin
          cnt_q <= '0;
          st_q  <= S_MUL;
        end
        S_MUL: begin
          if (cnt_q == LastCnt) begin
            st_q <= S_UPD;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_UPD: begin
          idx_q <= '0;
          st_q  <= fin_q ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (out_hs) begin
            if (idx_q == LastIdx) begin
              st_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign res[NUM_PRIMES] = '0;

  for (genvar g = 0; g < NUM_PRIMES; g++) begin : g_cell
    mru_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .mod_i    (mod_q[g]),
      .nb_res_i (res[g+1]),
      .res_o    (res[g])
    );
  end

  `MRU_NEVER(a_no_overlap, s_axis_tready && m_axis_tvalid, "input open while results wait")
  `MRU_ASSERT(a_busy_after_accept, in_hs |=> !s_axis_tready, "accepted two chunks at once")
  `MRU_ASSERT(a_end_of_burst, (out_hs && m_axis_tlast) |=> !m_axis_tvalid, "extra residue")

endmodule

>>> hdl/mru_cell.sv
// One lane cell: holds the state for one modulus and a stage of the result chain.
`timescale 1ns / 1ps
module mru_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mru_pkg::ctrl_t ctrl_i,
  input  mru_pkg::word_t mod_i,
  input  mru_pkg::word_t nb_res_i,
  output mru_pkg::word_t res_o
);
  import mru_pkg::*;

  word_t rr_q, w_q;
  word_t sw_q, sr_q;
  word_t xc_q, xw_q, xr_q, xb_q;
  word_t d_q, t_q, nw_q;
  word_t o_q;
  word_t sum;
  logic  m_ok;

  assign m_ok = (mod_i >= word_t'(2));
  assign sum  = add_mod(xr_q, t_q, mod_i);
  assign res_o = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_q <= '0;
      w_q  <= word_t'(1);
    end else if (ctrl_i.upd) begin
      if (!m_ok || ctrl_i.cap) begin
        rr_q <= '0;
        w_q  <= word_t'(1);
      end else begin
        rr_q <= sum;
        w_q  <= nw_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sw_q <= w_q;
      sr_q <= rr_q;
      xc_q <= '0;
      xw_q <= '0;
      xr_q <= '0;
      xb_q <= word_t'(1);
    end else if (ctrl_i.red) begin
      xc_q <= red_step(xc_q, ctrl_i.bit_c, mod_i);
      xw_q <= red_step(xw_q, sw_q[WordBits-1], mod_i);
      xr_q <= red_step(xr_q, sr_q[WordBits-1], mod_i);
      sw_q <= {sw_q[WordBits-2:0], 1'b0};
      sr_q <= {sr_q[WordBits-2:0], 1'b0};
      if (ctrl_i.base_en) begin
        xb_q <= red_step(xb_q, 1'b0, mod_i);
      end
    end else if (ctrl_i.prep) begin
      d_q  <= xw_q;
      t_q  <= '0;
      nw_q <= '0;
    end else if (ctrl_i.mul) begin
      if (xc_q[0]) begin
        t_q <= add_mod(t_q, d_q, mod_i);
      end
      if (xb_q[0]) begin
        nw_q <= add_mod(nw_q, d_q, mod_i);
      end
      d_q  <= add_mod(d_q, d_q, mod_i);
      xc_q <= {1'b0, xc_q[WordBits-1:1]};
      xb_q <= {1'b0, xb_q[WordBits-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      o_q <= m_ok ? sum : '0;
    end else if (ctrl_i.shift) begin
      o_q <= nb_res_i;
    end
  end

endmodule
